[hdl/lcu_pkg.sv]
package lcu_pkg;

  // Line gathering
  localparam int unsigned LINE_CAPACITY = 32;
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned HEAD_BYTES    = 5;
  localparam int unsigned HEAD_IDX_W    = $clog2(HEAD_BYTES);

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input opcodes
  localparam logic [2:0] OP_RX      = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_TURN    = 3'd2;
  localparam logic [2:0] OP_BRAKE   = 3'd3;
  localparam logic [2:0] OP_TAIL    = 3'd4;
  localparam logic [2:0] OP_LOWBEAM = 3'd5;

  // Register indexes on the configuration port
  localparam logic REG_BLINK_ON     = 1'b0;
  localparam logic REG_BLINK_PERIOD = 1'b1;

  localparam logic [7:0] BLINK_ON_RESET     = 8'd10;
  localparam logic [7:0] BLINK_PERIOD_RESET = 8'd20;

  // Bytes
  localparam logic [7:0] SYNC_A   = 8'hAA;
  localparam logic [7:0] SYNC_B   = 8'h55;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] STATE_ON  = 8'h01;
  localparam logic [7:0] STATE_OFF = 8'h00;

  localparam logic [39:0] WORD_START = "START";
  localparam logic [31:0] WORD_STOP  = "STOP";
  localparam logic [15:0] WORD_OK    = "OK";

  // Lamp identifiers
  localparam logic [2:0] LAMP_LEFT    = 3'd2;
  localparam logic [2:0] LAMP_RIGHT   = 3'd3;
  localparam logic [2:0] LAMP_BRAKE   = 3'd4;
  localparam logic [2:0] LAMP_TAIL    = 3'd5;
  localparam logic [2:0] LAMP_LOWBEAM = 3'd6;

  // Byte positions within a frame
  localparam logic [2:0] POS_SYNC_A0 = 3'd0;
  localparam logic [2:0] POS_SYNC_B0 = 3'd1;
  localparam logic [2:0] POS_ID      = 3'd2;
  localparam logic [2:0] POS_STATE   = 3'd3;
  localparam logic [2:0] POS_SYNC_B1 = 3'd4;
  localparam logic [2:0] POS_SYNC_A1 = 3'd5;

  localparam logic KIND_BYTE      = 1'b0;
  localparam logic KIND_HEARTBEAT = 1'b1;

  // One unit of output work: a heartbeat result, or one or two frames.
  typedef struct packed {
    logic       hb;
    logic       two;
    logic [2:0] id0;
    logic       on0;
    logic [2:0] id1;
    logic       on1;
  } job_t;

endpackage

[hdl/lcu_front.sv]
module lcu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        opcode_i,
  input  logic [7:0]        rx_byte_i,
  input  logic signed [1:0] turn_request_i,
  input  logic              lamp_on_i,
  input  logic [7:0]        blink_on_ticks_i,
  input  logic [7:0]        blink_period_ticks_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output lcu_pkg::job_t     job_o
);

  logic [lcu_pkg::LEN_W-1:0] len_q, len_d;
  logic                      ovf_q, ovf_d;
  logic [1:0]                turn_q, turn_d;
  logic [7:0]                cnt_q, cnt_d;
  logic [7:0]                last_q, last_d;
  logic [7:0]                head_q [lcu_pkg::HEAD_BYTES];
  logic                      store_en;
  logic                      accept;
  logic [lcu_pkg::LEN_W-1:0] word_len;
  logic                      is_start, is_stop, is_ok;
  logic [8:0]                period;
  logic [8:0]                cnt_ext;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign word_len   = len_q - lcu_pkg::LEN_W'(1);
  assign period     = (blink_period_ticks_i == 8'd0) ? 9'd256 : {1'b0, blink_period_ticks_i};
  assign cnt_ext    = {1'b0, cnt_q};

  // Only the first five bytes can decide a match; an overflowed line is
  // rejected separately, so the rest of the line need not be kept.
  assign is_start = (word_len == lcu_pkg::LEN_W'(5)) &&
                    ({head_q[0], head_q[1], head_q[2], head_q[3], head_q[4]} ==
                     lcu_pkg::WORD_START);
  assign is_stop  = (word_len == lcu_pkg::LEN_W'(4)) &&
                    ({head_q[0], head_q[1], head_q[2], head_q[3]} == lcu_pkg::WORD_STOP);
  assign is_ok    = (word_len == lcu_pkg::LEN_W'(2)) &&
                    ({head_q[0], head_q[1]} == lcu_pkg::WORD_OK);

  always_comb begin
    len_d    = len_q;
    ovf_d    = ovf_q;
    turn_d   = turn_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    store_en = 1'b0;
    push_o   = 1'b0;
    job_o    = '0;
    if (accept) begin
      unique case (opcode_i)
        lcu_pkg::OP_RX: begin
          if (rx_byte_i == lcu_pkg::CHAR_LF && len_q == '0) begin
            // A line feed on an empty line is dropped.
          end else if (rx_byte_i == lcu_pkg::CHAR_LF && last_q == lcu_pkg::CHAR_CR) begin
            // SHOW and any other line give nothing.
            if (!ovf_q) begin
              if (is_start) begin
                push_o    = 1'b1;
                job_o.id0 = lcu_pkg::LAMP_LOWBEAM;
                job_o.on0 = 1'b1;
              end else if (is_stop) begin
                push_o    = 1'b1;
                job_o.id0 = lcu_pkg::LAMP_LOWBEAM;
              end else if (is_ok) begin
                push_o   = 1'b1;
                job_o.hb = 1'b1;
              end
            end
            len_d = '0;
            ovf_d = 1'b0;
          end else begin
            last_d = rx_byte_i;
            if (len_q < lcu_pkg::LEN_W'(lcu_pkg::LINE_CAPACITY)) begin
              store_en = 1'b1;
              len_d    = len_q + lcu_pkg::LEN_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        lcu_pkg::OP_TICK: begin
          if (turn_q != 2'd0) begin
            if (cnt_ext < period) begin
              push_o    = 1'b1;
              job_o.id0 = turn_q[1] ? lcu_pkg::LAMP_LEFT : lcu_pkg::LAMP_RIGHT;
              job_o.on0 = (cnt_q < blink_on_ticks_i);
            end
            if (cnt_ext >= period - 9'd1) begin
              cnt_d = '0;
            end else begin
              cnt_d = cnt_q + 8'd1;
            end
          end
        end
        lcu_pkg::OP_TURN: begin
          cnt_d  = '0;
          turn_d = turn_request_i;
          if (turn_request_i == 2'sd0) begin
            push_o    = 1'b1;
            job_o.two = 1'b1;
            job_o.id0 = lcu_pkg::LAMP_LEFT;
            job_o.id1 = lcu_pkg::LAMP_RIGHT;
          end
        end
        lcu_pkg::OP_BRAKE: begin
          push_o    = 1'b1;
          job_o.id0 = lcu_pkg::LAMP_BRAKE;
          job_o.on0 = lamp_on_i;
        end
        lcu_pkg::OP_TAIL: begin
          push_o    = 1'b1;
          job_o.id0 = lcu_pkg::LAMP_TAIL;
          job_o.on0 = lamp_on_i;
        end
        lcu_pkg::OP_LOWBEAM: begin
          push_o    = 1'b1;
          job_o.id0 = lcu_pkg::LAMP_LOWBEAM;
          job_o.on0 = lamp_on_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      turn_q <= '0;
      cnt_q  <= '0;
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      turn_q <= turn_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (store_en && len_q < lcu_pkg::LEN_W'(lcu_pkg::HEAD_BYTES)) begin
      head_q[len_q[lcu_pkg::HEAD_IDX_W-1:0]] <= rx_byte_i;
    end
  end

endmodule

[hdl/lcu_queue.sv]
module lcu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lcu_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lcu_pkg::job_t job_o
);

  lcu_pkg::job_t              mem_q [lcu_pkg::QUEUE_DEPTH];
  logic [lcu_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [lcu_pkg::QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == lcu_pkg::QCNT_W'(lcu_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + lcu_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + lcu_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + lcu_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - lcu_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

[hdl/lcu_back.sv]
module lcu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  lcu_pkg::job_t q_job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          kind_o,
  output logic [7:0]    tx_byte_o,
  output logic          frame_end_o,
  output logic          last_o
);

  lcu_pkg::job_t job_q, job_d;
  logic          busy_q, busy_d;
  logic [2:0]    idx_q, idx_d;
  logic          sel_q, sel_d;
  logic          valid_q, valid_d;
  logic          kind_q, kind_d;
  logic [7:0]    byte_q, byte_d;
  logic          fend_q, fend_d;
  logic          last_q, last_d;
  logic          advance;
  logic [2:0]    cur_id;
  logic          cur_on;
  logic          job_done;

  assign advance = !valid_q || out_ready_i;
  assign pop_o   = !busy_q && q_valid_i;
  assign cur_id  = sel_q ? job_q.id1 : job_q.id0;
  assign cur_on  = sel_q ? job_q.on1 : job_q.on0;
  assign job_done = !job_q.two || sel_q;

  always_comb begin
    job_d   = job_q;
    busy_d  = busy_q;
    idx_d   = idx_q;
    sel_d   = sel_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    fend_d  = fend_q;
    last_d  = last_q;
    if (pop_o) begin
      job_d  = q_job_i;
      busy_d = 1'b1;
      idx_d  = '0;
      sel_d  = 1'b0;
    end
    if (advance) begin
      valid_d = busy_q;
      if (busy_q) begin
        if (job_q.hb) begin
          kind_d = lcu_pkg::KIND_HEARTBEAT;
          byte_d = 8'h00;
          fend_d = 1'b0;
          last_d = 1'b1;
          busy_d = 1'b0;
        end else begin
          kind_d = lcu_pkg::KIND_BYTE;
          unique case (idx_q)
            lcu_pkg::POS_SYNC_A0: byte_d = lcu_pkg::SYNC_A;
            lcu_pkg::POS_SYNC_B0: byte_d = lcu_pkg::SYNC_B;
            lcu_pkg::POS_ID:      byte_d = {5'd0, cur_id};
            lcu_pkg::POS_STATE:   byte_d = cur_on ? lcu_pkg::STATE_ON : lcu_pkg::STATE_OFF;
            lcu_pkg::POS_SYNC_B1: byte_d = lcu_pkg::SYNC_B;
            default:              byte_d = lcu_pkg::SYNC_A;
          endcase
          fend_d = (idx_q == lcu_pkg::POS_SYNC_A1);
          last_d = fend_d && job_done;
          if (fend_d) begin
            idx_d = '0;
            if (job_done) begin
              busy_d = 1'b0;
            end else begin
              sel_d = 1'b1;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      idx_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    fend_q <= fend_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = byte_q;
  assign frame_end_o = fend_q;
  assign last_o      = last_q;

endmodule

[hdl/lamp_command_uart_controller.sv]
// With the back idle, a result-producing item passes the job queue, the back's job register
// and its output register before tvalid rises on the master side; bytes then follow one per
// cycle while tready stays high. The front takes one item per cycle while its four-job queue
// has room; the back emits one byte per cycle while tready stays high, loading each job first.
// Reset clears the line length, overflow flag, turn state, blink counter, job queue and
// output valid; the blink registers return to 10 and 20. No clearing pass is needed.
module lamp_command_uart_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // rx_byte[7:0], turn_request[9:8], lamp_on[10], zeros
  input  logic [2:0]  s_axis_tuser_i,  // opcode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // tx_byte[7:0]
  output logic [1:0]  m_axis_tuser_o,  // kind[0], frame_end[1]
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [7:0]    blink_on_q;
  logic [7:0]    blink_period_q;
  logic          cfg_write;
  logic          queue_full;
  logic          push;
  lcu_pkg::job_t push_job;
  logic          pop;
  logic          q_valid;
  lcu_pkg::job_t q_job;
  logic          out_kind;
  logic          out_fend;

  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o  = {24'd0, (paddr_i[2] == lcu_pkg::REG_BLINK_PERIOD) ? blink_period_q
                                                                        : blink_on_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_on_q     <= lcu_pkg::BLINK_ON_RESET;
      blink_period_q <= lcu_pkg::BLINK_PERIOD_RESET;
    end else if (cfg_write) begin
      if (paddr_i[2] == lcu_pkg::REG_BLINK_PERIOD) begin
        blink_period_q <= pwdata_i[7:0];
      end else begin
        blink_on_q <= pwdata_i[7:0];
      end
    end
  end

  lcu_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (s_axis_tvalid_i),
    .in_ready_o           (s_axis_tready_o),
    .opcode_i             (s_axis_tuser_i),
    .rx_byte_i            (s_axis_tdata_i[7:0]),
    .turn_request_i       (s_axis_tdata_i[9:8]),
    .lamp_on_i            (s_axis_tdata_i[10]),
    .blink_on_ticks_i     (blink_on_q),
    .blink_period_ticks_i (blink_period_q),
    .queue_full_i         (queue_full),
    .push_o               (push),
    .job_o                (push_job)
  );

  lcu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  lcu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kind_o      (out_kind),
    .tx_byte_o   (m_axis_tdata_o),
    .frame_end_o (out_fend),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = {out_fend, out_kind};

endmodule
